@@ rtl/core/ssrm_pkg.sv @@
package ssrm_pkg;

    // Display geometry
    localparam int NUM_DIGITS   = 6;
    localparam int STORE_DIGITS = 6;
    localparam int HALF_DIGITS  = 3;

    localparam logic [7:0]  BLANK_PATTERN  = 8'hFF;
    localparam logic [15:0] TIMEOUT_RESET  = 16'd300;
    localparam logic [3:0]  TOP_VIEW_RESET = 4'd0;
    localparam logic [3:0]  BOT_VIEW_RESET = 4'd2;
    localparam logic [3:0]  LABEL_OFFSET   = 4'd8;

    // Glyph indexes of the label letters (ASCII minus 55)
    localparam logic [4:0] GL_C = 5'd12;
    localparam logic [4:0] GL_D = 5'd13;
    localparam logic [4:0] GL_H = 5'd17;
    localparam logic [4:0] GL_I = 5'd18;
    localparam logic [4:0] GL_N = 5'd23;
    localparam logic [4:0] GL_O = 5'd24;
    localparam logic [4:0] GL_P = 5'd25;
    localparam logic [4:0] GL_S = 5'd28;
    localparam logic [4:0] GL_T = 5'd29;

    // Data sources selected by view bits [2:1]
    typedef logic [3:0][7:0] value_set_t;

    // Active-low glyphs: 0-9, then letters A..I, N, O, P, S, T
    function automatic logic [7:0] glyph(input logic [4:0] idx);
        logic [7:0] pat;
        unique case (idx)
            5'd0:    pat = 8'hC0;
            5'd1:    pat = 8'hF9;
            5'd2:    pat = 8'hA4;
            5'd3:    pat = 8'hB0;
            5'd4:    pat = 8'h99;
            5'd5:    pat = 8'h92;
            5'd6:    pat = 8'h82;
            5'd7:    pat = 8'hD8;
            5'd8:    pat = 8'h80;
            5'd9:    pat = 8'h90;
            5'd10:   pat = 8'h88;
            5'd11:   pat = 8'h83;
            5'd12:   pat = 8'hC6;
            5'd13:   pat = 8'hA1;
            5'd14:   pat = 8'h86;
            5'd15:   pat = 8'h8E;
            5'd16:   pat = 8'h82;
            5'd17:   pat = 8'h8B;
            5'd18:   pat = 8'hFB;
            5'd23:   pat = 8'hAB;
            5'd24:   pat = 8'hA3;
            5'd25:   pat = 8'h8C;
            5'd28:   pat = 8'h93;
            5'd29:   pat = 8'h87;
            default: pat = 8'h11;
        endcase
        return pat;
    endfunction

    // Letter of label code (PCH PCD SPH SPD INH IND OTH OTD) at a position
    function automatic logic [4:0] label_letter(input logic [2:0] code,
                                                input logic [1:0] pos);
        logic [4:0] l0;
        logic [4:0] l1;
        logic [4:0] l2;
        unique case (code[2:1])
            2'd0:    begin l0 = GL_P; l1 = GL_C; end
            2'd1:    begin l0 = GL_S; l1 = GL_P; end
            2'd2:    begin l0 = GL_I; l1 = GL_N; end
            default: begin l0 = GL_O; l1 = GL_T; end
        endcase
        l2 = code[0] ? GL_D : GL_H;
        unique case (pos)
            2'd0:    return l0;
            2'd1:    return l1;
            default: return l2;
        endcase
    endfunction

endpackage

@@ rtl/core/ssrm_digit.sv @@
module ssrm_digit (
    input  logic [3:0]              view,
    input  ssrm_pkg::value_set_t    vals,
    input  logic [1:0]              pos,
    output logic [7:0]              pattern
);
    import ssrm_pkg::*;

    logic [7:0]  v;
    logic [1:0]  hundreds;
    logic [6:0]  rem100;
    logic [14:0] tens_prod;
    logic [3:0]  tens;
    logic [3:0]  ones;

    assign v = vals[view[2:1]];

    // Decimal split: compare for hundreds, reciprocal multiply for tens
    always_comb
    begin
        if (v >= 8'd200)
        begin
            hundreds = 2'd2;
            rem100   = 7'(v - 8'd200);
        end
        else if (v >= 8'd100)
        begin
            hundreds = 2'd1;
            rem100   = 7'(v - 8'd100);
        end
        else
        begin
            hundreds = 2'd0;
            rem100   = v[6:0];
        end
        tens_prod = 15'(rem100) * 15'd205;
        tens      = tens_prod[14:11];
        ones      = 4'(rem100 - 7'(tens) * 7'd10);
    end

    // Pattern of this position: label, hex or decimal
    always_comb
    begin
        if (view[3])
            pattern = glyph(label_letter(view[2:0], pos));
        else if (!view[0])
        begin
            unique case (pos)
                2'd0:    pattern = BLANK_PATTERN;
                2'd1:    pattern = glyph({1'b0, v[7:4]});
                default: pattern = glyph({1'b0, v[3:0]});
            endcase
        end
        else
        begin
            unique case (pos)
                2'd0:    pattern = glyph({3'b000, hundreds});
                2'd1:    pattern = glyph({1'b0, tens});
                default: pattern = glyph({1'b0, ones});
            endcase
        end
    end

endmodule

@@ rtl/core/seven_segment_register_monitor.sv @@
// Channel   Direction  Handshake          Payload
// in        input      in_valid/in_stall  button, pc_value, sp_value, in_value, out_value
// out       output     out_valid/out_stall segments, digit_select
// cfg       input      cfg_valid/cfg_ready cfg_data (menu timeout)
//
// One item per cycle while out is not stalled; each item passes two registers (input register, result register).
// Menu update, formatting and the scan step for an item happen in the cycle it leaves
// the input register. Reset sets PC hex over SP hex, closes the menu, restarts the scan
// with a blank phase and sets the timeout to 300.
// A stall on out holds the result register; in stalls only when the input register
// is full and cannot move forward. cfg_ready is always high.
module seven_segment_register_monitor (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        button,
    input  logic [7:0]  pc_value,
    input  logic [7:0]  sp_value,
    input  logic [7:0]  in_value,
    input  logic [7:0]  out_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  segments,
    output logic [2:0]  digit_select,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);
    import ssrm_pkg::*;

    logic        s1_valid_reg;
    logic        s1_button_reg;
    value_set_t  s1_vals_reg;
    logic        s1_adv;
    logic        step;

    logic [15:0] menu_timeout_reg;
    logic [3:0]  top_view_reg,   top_view_next;
    logic [3:0]  bottom_view_reg, bottom_view_next;
    logic        menu_active_reg, menu_active_next;
    logic [15:0] menu_ticks_reg, menu_ticks_next;
    logic        button_held_reg, button_held_next;
    logic [2:0]  scan_index_reg, scan_index_next;
    logic        show_phase_reg, show_phase_next;

    logic        out_valid_reg;
    logic [7:0]  segments_reg, segments_next;
    logic [2:0]  digit_select_reg;

    logic [3:0]  dig_view;
    logic [1:0]  dig_pos;
    logic [7:0]  dig_pattern;

    // Handshakes
    assign s1_adv    = !out_valid_reg || !out_stall;
    assign step      = s1_valid_reg && s1_adv;
    assign in_stall  = s1_valid_reg && !s1_adv;
    assign cfg_ready = 1'b1;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            menu_timeout_reg <= TIMEOUT_RESET;
        else if (cfg_valid && cfg_ready)
            menu_timeout_reg <= cfg_data;
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (!in_stall)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_button_reg  <= button;
            s1_vals_reg[0] <= pc_value;
            s1_vals_reg[1] <= sp_value;
            s1_vals_reg[2] <= in_value;
            s1_vals_reg[3] <= out_value;
        end
    end

    // Button edge and menu timeout
    always_comb
    begin
        top_view_next    = top_view_reg;
        bottom_view_next = bottom_view_reg;
        menu_active_next = menu_active_reg;
        menu_ticks_next  = menu_ticks_reg;
        button_held_next = s1_button_reg;
        if (s1_button_reg && !button_held_reg)
        begin
            if (!menu_active_reg)
            begin
                bottom_view_next = top_view_reg + LABEL_OFFSET;
                top_view_next    = top_view_reg + LABEL_OFFSET;
                menu_active_next = 1'b1;
            end
            menu_ticks_next = '0;
            top_view_next   = top_view_next + 4'd1;
            if (top_view_next == 4'd0)
                top_view_next = LABEL_OFFSET;
        end
        if (menu_active_next)
        begin
            menu_ticks_next = menu_ticks_next + 16'd1;
            if (menu_ticks_next >= menu_timeout_reg)
            begin
                menu_active_next = 1'b0;
                menu_ticks_next  = '0;
                top_view_next    = top_view_next - LABEL_OFFSET;
                bottom_view_next = bottom_view_next - LABEL_OFFSET;
            end
        end
    end

    // Scan step
    always_comb
    begin
        scan_index_next = scan_index_reg;
        show_phase_next = !show_phase_reg;
        if (show_phase_reg)
        begin
            scan_index_next = scan_index_reg + 3'd1;
            if (int'(scan_index_next) >= NUM_DIGITS)
                scan_index_next = '0;
        end
    end

    // Pick half and position of the digit being shown
    always_comb
    begin
        if (int'(scan_index_next) < HALF_DIGITS)
        begin
            dig_view = bottom_view_next;
            dig_pos  = scan_index_next[1:0];
        end
        else
        begin
            dig_view = top_view_next;
            dig_pos  = 2'(scan_index_next - 3'(HALF_DIGITS));
        end
    end

    ssrm_digit u_digit (
        .view    (dig_view),
        .vals    (s1_vals_reg),
        .pos     (dig_pos),
        .pattern (dig_pattern)
    );

    always_comb
    begin
        if (!show_phase_reg || int'(scan_index_next) >= STORE_DIGITS)
            segments_next = BLANK_PATTERN;
        else
            segments_next = dig_pattern;
    end

    // State registers, advanced once per item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_view_reg    <= TOP_VIEW_RESET;
            bottom_view_reg <= BOT_VIEW_RESET;
            menu_active_reg <= 1'b0;
            menu_ticks_reg  <= '0;
            button_held_reg <= 1'b0;
            scan_index_reg  <= '0;
            show_phase_reg  <= 1'b0;
        end
        else if (step)
        begin
            top_view_reg    <= top_view_next;
            bottom_view_reg <= bottom_view_next;
            menu_active_reg <= menu_active_next;
            menu_ticks_reg  <= menu_ticks_next;
            button_held_reg <= button_held_next;
            scan_index_reg  <= scan_index_next;
            show_phase_reg  <= show_phase_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_adv)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            segments_reg     <= segments_next;
            digit_select_reg <= scan_index_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign segments     = segments_reg;
    assign digit_select = digit_select_reg;

    // Checks
    assert property (@(posedge clk) disable iff (!rst_n)
        !menu_active_reg |-> menu_ticks_reg == 16'd0)
        else $error("menu tick count nonzero while menu closed");

    assert property (@(posedge clk) disable iff (!rst_n)
        top_view_reg[3] == menu_active_reg && bottom_view_reg[3] == menu_active_reg)
        else $error("view label bit disagrees with menu state");

    assert property (@(posedge clk) disable iff (!rst_n)
        int'(scan_index_reg) < NUM_DIGITS)
        else $error("scan index out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> s1_valid_reg)
        else $error("accepted item lost from input register");

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    import ssrm_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int LETTER_BASE  = 55;
    localparam int MAX_REPORTS  = 200;

    // One scanned digit as the display driver shows it
    typedef struct packed {
        logic [7:0] segments;
        logic [2:0] digit_select;
    } scan_result_t;

    // Tracks views, menu and scan position and holds the digits still due
    class digit_scan_tracker;
        logic [15:0] timeout_ticks;
        logic [3:0]  top_code;
        logic [3:0]  bottom_code;
        bit          menu_open;
        logic [15:0] menu_count;
        bit          btn_held;
        logic [2:0]  scan_pos;
        bit          lit_phase;
        logic [7:0]  digit_store [STORE_DIGITS];
        scan_result_t scan_due [$];
        int          errors;
        logic [7:0]  glyph_rom [30] = '{
            8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hD8, 8'h80, 8'h90,
            8'h88, 8'h83, 8'hC6, 8'hA1, 8'h86, 8'h8E, 8'h82, 8'h8B, 8'hFB, 8'h11,
            8'h11, 8'h11, 8'h11, 8'hAB, 8'hA3, 8'h8C, 8'h11, 8'h11, 8'h93, 8'h87
        };
        string       label_names [8] = '{"PCH", "PCD", "SPH", "SPD",
                                         "INH", "IND", "OTH", "OTD"};

        function new();
            timeout_ticks = TIMEOUT_RESET;
            top_code      = TOP_VIEW_RESET;
            bottom_code   = BOT_VIEW_RESET;
            menu_open     = 1'b0;
            menu_count    = '0;
            btn_held      = 1'b0;
            scan_pos      = '0;
            lit_phase     = 1'b0;
            errors        = 0;
            foreach (digit_store[i])
                digit_store[i] = '0;
        endfunction

        function void set_timeout(logic [15:0] ticks);
            timeout_ticks = ticks;
        endfunction

        function logic [7:0] glyph_of(int idx);
            if (idx < 0 || idx >= 30)
                return BLANK_PATTERN;
            return glyph_rom[idx];
        endfunction

        // base is the leftmost digit of the half
        function void format_half(int base, logic [3:0] code, value_set_t vals);
            logic [7:0] v;
            string      name;
            v = vals[code[2:1]];
            if (code[3])
            begin
                name = label_names[code[2:0]];
                for (int k = 0; k < HALF_DIGITS; k++)
                    digit_store[base + k] = glyph_of(int'(name[k]) - LETTER_BASE);
            end
            else if (!code[0])
            begin
                digit_store[base + 2] = glyph_of(int'(v[3:0]));
                digit_store[base + 1] = glyph_of(int'(v[7:4]));
                digit_store[base]     = BLANK_PATTERN;
            end
            else
            begin
                digit_store[base + 2] = glyph_of(int'(v) % 10);
                digit_store[base + 1] = glyph_of((int'(v) / 10) % 10);
                digit_store[base]     = glyph_of((int'(v) / 100) % 10);
            end
        endfunction

        // One accepted tick: menu update, formatting, then one scan step
        function void take_tick(bit btn, logic [7:0] pc, logic [7:0] sp,
                                logic [7:0] iv, logic [7:0] ov);
            value_set_t   vals;
            scan_result_t res;
            vals = {ov, iv, sp, pc};

            if (!btn)
                btn_held = 1'b0;
            if (btn && !btn_held)
            begin
                btn_held = 1'b1;
                if (!menu_open)
                begin
                    bottom_code = top_code + LABEL_OFFSET;
                    top_code    = top_code + LABEL_OFFSET;
                    menu_open   = 1'b1;
                end
                menu_count = '0;
                top_code   = top_code + 4'd1;
                if (top_code == 4'd0)
                    top_code = LABEL_OFFSET;
            end
            if (menu_open)
            begin
                menu_count = menu_count + 16'd1;
                if (menu_count >= timeout_ticks)
                begin
                    menu_open   = 1'b0;
                    menu_count  = '0;
                    top_code    = top_code - LABEL_OFFSET;
                    bottom_code = bottom_code - LABEL_OFFSET;
                end
            end

            format_half(HALF_DIGITS, top_code, vals);
            format_half(0, bottom_code, vals);

            // blank phase alternates with the next digit
            if (lit_phase)
            begin
                lit_phase = 1'b0;
                scan_pos  = scan_pos + 3'd1;
                if (int'(scan_pos) >= NUM_DIGITS)
                    scan_pos = '0;
                res.segments = (int'(scan_pos) < STORE_DIGITS) ? digit_store[scan_pos]
                                                               : BLANK_PATTERN;
            end
            else
            begin
                lit_phase    = 1'b1;
                res.segments = BLANK_PATTERN;
            end
            res.digit_select = scan_pos;
            scan_due.push_back(res);
        endfunction

        function void check_scan(logic [7:0] segs, logic [2:0] sel);
            scan_result_t want;
            if (scan_due.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected transfer, segments %02h digit_select %0d",
                             $time, segs, sel);
                return;
            end
            want = scan_due.pop_front();
            if (segs !== want.segments || sel !== want.digit_select)
            begin
                errors++;
                // report cap keeps a broken run readable
                if (errors <= MAX_REPORTS)
                    $display("%0t: segments expected %02h got %02h, digit_select expected %0d got %0d",
                             $time, want.segments, segs, want.digit_select, sel);
            end
        endfunction

        function int pending();
            return scan_due.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_stall;
    logic        button       = 1'b0;
    logic [7:0]  pc_value     = '0;
    logic [7:0]  sp_value     = '0;
    logic [7:0]  in_value     = '0;
    logic [7:0]  out_value    = '0;
    logic        out_valid;
    logic        out_stall    = 1'b0;
    logic [7:0]  segments;
    logic [2:0]  digit_select;
    logic        cfg_valid    = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data     = '0;

    int unsigned send_idle_pct  = 0;
    int unsigned stall_pct      = 0;
    int unsigned cur_timeout    = 32'(TIMEOUT_RESET);
    int          cycle_count    = 0;

    // timeouts and lengths of the random phases; idle mode follows the index
    int unsigned phase_timeout [9] = '{300, 1, 65535, 0, 2, 5, 13, 37, 9};
    int          phase_items   [9] = '{400, 150, 120, 120, 160, 180, 220, 220, 200};

    digit_scan_tracker tracker = new();

    seven_segment_register_monitor dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .button       (button),
        .pc_value     (pc_value),
        .sp_value     (sp_value),
        .in_value     (in_value),
        .out_value    (out_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .segments     (segments),
        .digit_select (digit_select),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("testbench: FAIL");
        $finish;
    end

    // Receiver stall
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // Track every transfer on all three channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                tracker.set_timeout(cfg_data);
            if (in_valid && !in_stall)
                tracker.take_tick(button, pc_value, sp_value, in_value, out_value);
            if (out_valid && !out_stall)
                tracker.check_scan(segments, digit_select);
        end
    end

    function automatic logic [7:0] pick_value();
        logic [7:0] corner [8];
        corner = '{8'd0, 8'd255, 8'd9, 8'd10, 8'd99, 8'd100, 8'h0F, 8'hF0};
        if ($urandom_range(7) == 0)
            return corner[$urandom_range(7)];
        return 8'($urandom);
    endfunction

    // One tick transfer with explicit values
    task automatic send_values(input logic btn, input logic [7:0] pc, input logic [7:0] sp,
                               input logic [7:0] iv, input logic [7:0] ov);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        button    <= btn;
        pc_value  <= pc;
        sp_value  <= sp;
        in_value  <= iv;
        out_value <= ov;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic send_tick(input logic btn);
        send_values(btn, pick_value(), pick_value(), pick_value(), pick_value());
    endtask

    // Sender quiet until every digit due has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.pending() != 0);
    endtask

    task automatic write_timeout(input logic [15:0] ticks);
        cfg_valid <= 1'b1;
        cfg_data  <= ticks;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid   <= 1'b0;
        cur_timeout = 32'(ticks);
    endtask

    // Mostly press/release sequences with gaps around the timeout, some noise
    task automatic run_phase(input int items);
        int sent;
        int hold;
        int rest;
        int span;
        sent = 0;
        while (sent < items)
        begin
            if ($urandom_range(9) == 0)
            begin
                send_tick(1'($urandom_range(1)));
                sent++;
            end
            else
            begin
                hold = $urandom_range(1, 4);
                span = (cur_timeout * 2 + 4 > 40) ? 40 : int'(cur_timeout) * 2 + 4;
                if (cur_timeout <= 320 && $urandom_range(5) == 0)
                    rest = int'(cur_timeout) + $urandom_range(0, 3);
                else
                    rest = $urandom_range(0, span);
                repeat (hold) send_tick(1'b1);
                repeat (rest) send_tick(1'b0);
                sent += hold + rest;
            end
        end
    endtask

    task automatic set_idle_mode(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 81; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 81; end
            default: begin send_idle_pct = 29; stall_pct = 29; end
        endcase
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: value extremes in the reset view, then a full lap of the labels
        send_values(1'b0, 8'd0,   8'd0,   8'd0,   8'd0);
        send_values(1'b0, 8'd255, 8'd255, 8'd255, 8'd255);
        send_values(1'b0, 8'h0F,  8'hF0,  8'h5A,  8'hA5);
        send_values(1'b0, 8'd99,  8'd100, 8'd9,   8'd10);
        send_values(1'b0, 8'd255, 8'd0,   8'd255, 8'd0);
        send_values(1'b0, 8'd0,   8'd255, 8'd0,   8'd255);
        send_values(1'b0, 8'hAB,  8'hCD,  8'hEF,  8'h12);
        send_values(1'b0, 8'h34,  8'h56,  8'h78,  8'h9A);
        repeat (8)
        begin
            send_tick(1'b1);
            send_tick(1'b0);
        end

        // Random phases, each with its own timeout and idle mode
        for (int p = 0; p < 9; p++)
        begin
            if (p != 0)
            begin
                drain_results();
                write_timeout(16'(phase_timeout[p]));
            end
            set_idle_mode(p % 4);
            if (p == 5)
            begin
                run_phase(phase_items[p] / 2);
                drain_results();
                run_phase(phase_items[p] / 2);
            end
            else
                run_phase(phase_items[p]);
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
